// ===== hw/rtl/ppe_pkg.sv =====
// Shared types and constants for the pivoted pairwise elimination block.
`default_nettype none
package ppe_pkg;

  localparam int unsigned DimDefault = 16;
  localparam int unsigned ReqW       = 3;
  localparam int unsigned IdxInW     = 4;
  localparam int unsigned DataW      = 32;
  localparam int unsigned StatW      = 2;
  localparam int unsigned InTdataW   = 48;
  localparam int unsigned OutTdataW  = 40;

  typedef enum logic [2:0] {
    REQ_WR_MAT   = 3'd0,
    REQ_WR_VEC   = 3'd1,
    REQ_RD_MAT   = 3'd2,
    REQ_RD_VEC   = 3'd3,
    REQ_ROW_STEP = 3'd4,
    REQ_COL_STEP = 3'd5
  } req_e;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOP  = 2'd1;
  localparam logic [1:0] ST_SWAP = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WR_REQ, OP_RD_REQ, OP_RES_RD, OP_SET_NOP,
    OP_RD_D, OP_RD_E, OP_LATCH_E, OP_DIV_INIT, OP_DIV_STEP, OP_WR_RC,
    OP_WR_PIV, OP_LA, OP_LB, OP_MUL, OP_WE, OP_WP, OP_INC, OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic vec;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic rc_ok;
    logic r_ok;
    logic step_ok;
    logic both_zero;
    logic swap;
    logic div_last;
    logic loop_empty;
    logic loop_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pivoted_pairwise_elimination.sv =====
// Top level: Q16.16 matrix store with pivoted pairwise elimination steps.
//
//  channel  dir  tdata fields (low bit up)
//  s_axis   in   req_type[2:0] row_index[6:3] col_index[10:7] write_value[42:11]
//  m_axis   out  read_value[31:0] step_status[33:32]
//
// One item at a time. A step's length grows with n, the line length, and
// more so on a swap; the divider and the single matrix memory port set it.
// Reset clears control only; stores are undefined until written. A stalled
// result waits in the output register while the next item is accepted.
`default_nettype none
module pivoted_pairwise_elimination #(
  parameter int unsigned DIM = ppe_pkg::DimDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // req_type, row_index, col_index, write_value
  input  wire logic [ppe_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // read_value, step_status
  output logic [ppe_pkg::OutTdataW-1:0]        m_axis_tdata
);
  import ppe_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [DataW-1:0] out_value;
  logic [StatW-1:0] out_status;

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppe_dp #(.DIM(DIM)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_req_i     (s_axis_tdata[2:0]),
    .in_row_i     (s_axis_tdata[6:3]),
    .in_col_i     (s_axis_tdata[10:7]),
    .in_value_i   (s_axis_tdata[42:11]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'd0, out_status, out_value};

endmodule
`default_nettype wire

// ===== hw/rtl/ppe_ctrl.sv =====
// Sequencer for requests and elimination steps.
`default_nettype none
module ppe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ppe_pkg::sts_t sts_i,
  output ppe_pkg::cmd_t      cmd_o
);
  import ppe_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DECODE  = 16'h0002,
    S_RDWAIT  = 16'h0004,
    S_FETCH_E = 16'h0008,
    S_CHECK   = 16'h0010,
    S_EVAL    = 16'h0020,
    S_DIV     = 16'h0040,
    S_WR_RC   = 16'h0080,
    S_WR_PIV  = 16'h0100,
    S_LA      = 16'h0200,
    S_LB      = 16'h0400,
    S_MUL     = 16'h0800,
    S_WE      = 16'h1000,
    S_WP      = 16'h2000,
    S_NEXT    = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   vec_q, vec_d;

  always_comb begin
    state_d    = state_q;
    vec_d      = vec_q;
    cmd_o.op   = OP_NONE;
    cmd_o.vec  = vec_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        vec_d      = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.req)
          REQ_WR_MAT: if (sts_i.rc_ok) cmd_o.op = OP_WR_REQ;
          REQ_WR_VEC: if (sts_i.r_ok) cmd_o.op = OP_WR_REQ;
          REQ_RD_MAT: begin
            if (sts_i.rc_ok) begin
              cmd_o.op = OP_RD_REQ;
              state_d  = S_RDWAIT;
            end
          end
          REQ_RD_VEC: begin
            if (sts_i.r_ok) begin
              cmd_o.op = OP_RD_REQ;
              state_d  = S_RDWAIT;
            end
          end
          REQ_ROW_STEP, REQ_COL_STEP: begin
            if (sts_i.step_ok) begin
              cmd_o.op = OP_RD_D;
              state_d  = S_FETCH_E;
            end else begin
              cmd_o.op = OP_SET_NOP;
            end
          end
          default: cmd_o.op = OP_NONE;
        endcase
      end
      S_RDWAIT: begin
        cmd_o.op = OP_RES_RD;
        state_d  = S_DONE;
      end
      S_FETCH_E: begin
        cmd_o.op = OP_RD_E;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.op = OP_LATCH_E;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.both_zero) begin
          cmd_o.op = OP_SET_NOP;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) state_d = S_WR_RC;
      end
      S_WR_RC: begin
        cmd_o.op = OP_WR_RC;
        if (sts_i.swap) begin
          state_d = S_WR_PIV;
        end else begin
          vec_d   = sts_i.loop_empty;
          state_d = S_LA;
        end
      end
      S_WR_PIV: begin
        cmd_o.op = OP_WR_PIV;
        vec_d    = sts_i.loop_empty;
        state_d  = S_LA;
      end
      S_LA: begin
        cmd_o.op = OP_LA;
        state_d  = S_LB;
      end
      S_LB: begin
        cmd_o.op = OP_LB;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_WE;
      end
      S_WE: begin
        cmd_o.op = OP_WE;
        if (sts_i.swap) state_d = S_WP;
        else state_d = vec_q ? S_DONE : S_NEXT;
      end
      S_WP: begin
        cmd_o.op = OP_WP;
        state_d  = vec_q ? S_DONE : S_NEXT;
      end
      S_NEXT: begin
        cmd_o.op = OP_INC;
        if (sts_i.loop_last) vec_d = 1'b1;
        state_d = S_LA;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_PUBLISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vec_q   <= vec_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ppe_dp.sv =====
// Datapath: matrix and vector memories, divider, multiply-update, result register.
`default_nettype none
module ppe_dp #(
  parameter int unsigned DIM = ppe_pkg::DimDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ppe_pkg::cmd_t               cmd_i,
  output ppe_pkg::sts_t                    sts_o,
  input  wire logic [ppe_pkg::ReqW-1:0]    in_req_i,
  input  wire logic [ppe_pkg::IdxInW-1:0]  in_row_i,
  input  wire logic [ppe_pkg::IdxInW-1:0]  in_col_i,
  input  wire logic [ppe_pkg::DataW-1:0]   in_value_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [ppe_pkg::DataW-1:0]        out_value_o,
  output logic [ppe_pkg::StatW-1:0]        out_status_o
);
  import ppe_pkg::*;

  localparam int unsigned IW = $clog2(DIM);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned AW = $clog2(DIM * DIM);

  logic [DataW-1:0] mat_mem [DIM*DIM];
  logic [DataW-1:0] vec_mem [DIM];

  req_e              req_q;
  logic [IdxInW-1:0] row_q, col_q;
  logic [DataW-1:0]  wv_q, res_value_q, d_q, e_q, a_q, b_q, x_q, mrd_q, vrd_q;
  logic [StatW-1:0]  res_status_q;
  logic              swap_q, neg_q;
  logic [32:0]       rem_q;
  logic [31:0]       den_q;
  logic [16:0]       quo_q;
  logic [4:0]        dcnt_q;
  logic signed [17:0] m_q;
  logic signed [49:0] prod_q;
  logic [CW-1:0]     i_q;
  logic              out_valid_q;
  logic [DataW-1:0]  out_value_q;
  logic [StatW-1:0]  out_status_q;

  logic              r_ok, c_ok, is_col;
  logic [IW-1:0]     rix, cix, pv, ev, iix;
  logic [CW-1:0]     lo, hi;
  logic [AW-1:0]     p_addr, e_addr, piv_addr, rc_addr, m_addr;
  logic [IW-1:0]     v_addr;
  logic              m_we, v_we;
  logic [DataW-1:0]  m_wdata, v_wdata, rd, x_sel, upd_val;
  logic signed [31:0] y_sel;
  logic [31:0]       abs_d, abs_e;
  logic              swap_n;
  logic [32:0]       div_t;
  logic              div_ge;
  logic signed [33:0] ptr;
  logic signed [34:0] diff;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] rw, input logic [IW-1:0] cl);
    return AW'(rw * DIM + cl);
  endfunction

  always_comb begin
    r_ok     = 32'(row_q) < DIM;
    c_ok     = 32'(col_q) < DIM;
    rix      = IW'(row_q);
    cix      = IW'(col_q);
    is_col   = (req_q == REQ_COL_STEP);
    pv       = is_col ? rix : cix;
    ev       = is_col ? cix : rix;
    lo       = is_col ? '0 : CW'(cix) + CW'(1);
    hi       = is_col ? CW'(rix) : CW'(DIM);
    iix      = i_q[IW-1:0];
    p_addr   = is_col ? maddr(iix, pv) : maddr(pv, iix);
    e_addr   = is_col ? maddr(iix, ev) : maddr(ev, iix);
    piv_addr = maddr(pv, pv);
    rc_addr  = maddr(rix, cix);
    rd       = cmd_i.vec ? vrd_q : mrd_q;

    abs_d  = d_q[31] ? (~d_q + 32'd1) : d_q;
    abs_e  = e_q[31] ? (~e_q + 32'd1) : e_q;
    swap_n = abs_e > abs_d;
    div_t  = (dcnt_q == 5'd16) ? rem_q : {rem_q[31:0], 1'b0};
    div_ge = div_t >= {1'b0, den_q};

    x_sel = swap_q ? a_q : rd;
    y_sel = swap_q ? $signed(rd) : $signed(a_q);

    // truncate product toward zero, then saturating subtract
    ptr  = $signed(prod_q[49:16]) + $signed({33'd0, prod_q[49] && (prod_q[15:0] != '0)});
    diff = $signed({{3{x_q[31]}}, x_q}) - $signed({ptr[33], ptr});
    if (diff[34:31] == 4'b0000 || diff[34:31] == 4'b1111) upd_val = diff[31:0];
    else if (diff[34]) upd_val = 32'h8000_0000;
    else upd_val = 32'h7fff_ffff;
  end

  always_comb begin
    m_addr  = rc_addr;
    m_we    = 1'b0;
    m_wdata = wv_q;
    v_addr  = rix;
    v_we    = 1'b0;
    v_wdata = wv_q;
    case (cmd_i.op)
      OP_WR_REQ: begin
        m_we = (req_q == REQ_WR_MAT);
        v_we = (req_q == REQ_WR_VEC);
      end
      OP_RD_D: m_addr = piv_addr;
      OP_WR_RC: begin
        m_we    = 1'b1;
        m_wdata = '0;
      end
      OP_WR_PIV: begin
        m_addr  = piv_addr;
        m_we    = 1'b1;
        m_wdata = e_q;
      end
      OP_LA: begin
        m_addr = p_addr;
        v_addr = pv;
      end
      OP_LB: begin
        m_addr = e_addr;
        v_addr = ev;
      end
      OP_WE: begin
        m_addr  = e_addr;
        v_addr  = ev;
        m_we    = !cmd_i.vec;
        v_we    = cmd_i.vec;
        m_wdata = upd_val;
        v_wdata = upd_val;
      end
      OP_WP: begin
        m_addr  = p_addr;
        v_addr  = pv;
        m_we    = !cmd_i.vec;
        v_we    = cmd_i.vec;
        m_wdata = b_q;
        v_wdata = b_q;
      end
      default: m_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mat_mem[m_addr] <= m_wdata;
    mrd_q <= mat_mem[m_addr];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) vec_mem[v_addr] <= v_wdata;
    vrd_q <= vec_mem[v_addr];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q        <= req_e'(in_req_i);
        row_q        <= in_row_i;
        col_q        <= in_col_i;
        wv_q         <= in_value_i;
        res_value_q  <= '0;
        res_status_q <= ST_DONE;
      end
      OP_RES_RD:   res_value_q <= (req_q == REQ_RD_MAT) ? mrd_q : vrd_q;
      OP_SET_NOP:  res_status_q <= ST_NOP;
      OP_RD_E:     d_q <= mrd_q;
      OP_LATCH_E:  e_q <= mrd_q;
      OP_DIV_INIT: begin
        swap_q <= swap_n;
        neg_q  <= d_q[31] ^ e_q[31];
        rem_q  <= {1'b0, swap_n ? abs_d : abs_e};
        den_q  <= swap_n ? abs_e : abs_d;
        quo_q  <= '0;
        dcnt_q <= 5'd16;
      end
      OP_DIV_STEP: begin
        rem_q  <= div_ge ? div_t - {1'b0, den_q} : div_t;
        quo_q  <= {quo_q[15:0], div_ge};
        dcnt_q <= dcnt_q - 5'd1;
      end
      OP_WR_RC: begin
        m_q          <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
        i_q          <= lo;
        res_status_q <= swap_q ? ST_SWAP : ST_DONE;
      end
      OP_LB:  a_q <= rd;
      OP_MUL: begin
        prod_q <= m_q * y_sel;
        x_q    <= x_sel;
        b_q    <= rd;
      end
      OP_INC: i_q <= i_q + CW'(1);
      default: i_q <= i_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_PUBLISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUBLISH) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  always_comb begin
    sts_o.req        = req_q;
    sts_o.rc_ok      = r_ok && c_ok;
    sts_o.r_ok       = r_ok;
    sts_o.step_ok    = r_ok && c_ok && (row_q != col_q);
    sts_o.both_zero  = (d_q == '0) && (e_q == '0);
    sts_o.swap       = swap_q;
    sts_o.div_last   = (dcnt_q == 5'd0);
    sts_o.loop_empty = lo >= hi;
    sts_o.loop_last  = i_q == hi - CW'(1);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_DIV_STEP |-> rem_q <= {1'b0, den_q})
    else $error("divider remainder exceeds divisor");
  a_quo_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_WR_RC |-> quo_q <= 17'h10000)
    else $error("multiplier magnitude above one");
  a_nz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_DIV_INIT |-> (d_q != '0 || e_q != '0))
    else $error("division started with both operands zero");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for pivoted_pairwise_elimination: predicts every item and checks results in order.
`timescale 1ns / 1ps
module tb_top;
  import ppe_pkg::*;

  localparam int unsigned Dim = 16;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic [1:0]  step_status;
    logic [31:0] read_value;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InTdataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  logic [31:0] mat_model [Dim*Dim];
  logic [31:0] rhs_model [Dim];
  outcome_t pending_q [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  longint cycles = 0;

  pivoted_pairwise_elimination #(.DIM(Dim)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [31:0] reduce(logic [31:0] a, longint m, logic [31:0] b);
    longint p;
    p = (m * sx(b)) / 65536;
    return sat(sx(a) - p);
  endfunction

  function automatic logic [1:0] eliminate(bit col, int unsigned r, int unsigned c);
    int unsigned piv, lo, hi, keep, elx, pl, el;
    longint d, e, m;
    logic [31:0] tx, ty;
    piv = col ? r : c;
    lo = col ? 0 : c + 1;
    hi = col ? r : Dim;
    keep = col ? r : c;
    elx = col ? c : r;
    d = sx(mat_model[piv*Dim+piv]);
    e = sx(mat_model[r*Dim+c]);
    if (d == 0 && e == 0) return ST_NOP;
    mat_model[r*Dim+c] = '0;
    if ((d < 0 ? -d : d) >= (e < 0 ? -e : e)) begin
      m = (e * 65536) / d;
      for (int unsigned i = lo; i < hi; i++) begin
        el = col ? i*Dim+c : r*Dim+i;
        pl = col ? i*Dim+r : c*Dim+i;
        mat_model[el] = reduce(mat_model[el], m, mat_model[pl]);
      end
      rhs_model[elx] = reduce(rhs_model[elx], m, rhs_model[keep]);
      return ST_DONE;
    end
    m = (d * 65536) / e;
    mat_model[piv*Dim+piv] = sat(e);
    for (int unsigned i = lo; i < hi; i++) begin
      pl = col ? i*Dim+r : c*Dim+i;
      el = col ? i*Dim+c : r*Dim+i;
      tx = mat_model[pl];
      ty = mat_model[el];
      mat_model[pl] = ty;
      mat_model[el] = reduce(tx, m, ty);
    end
    tx = rhs_model[keep];
    ty = rhs_model[elx];
    rhs_model[keep] = ty;
    rhs_model[elx] = reduce(tx, m, ty);
    return ST_SWAP;
  endfunction

  function automatic outcome_t predict(req_e req, int unsigned r, int unsigned c,
                                       logic [31:0] wv);
    outcome_t o;
    o = '0;
    case (req)
      REQ_WR_MAT: mat_model[r*Dim+c] = wv;
      REQ_WR_VEC: rhs_model[r] = wv;
      REQ_RD_MAT: o.read_value = mat_model[r*Dim+c];
      REQ_RD_VEC: o.read_value = rhs_model[r];
      REQ_ROW_STEP, REQ_COL_STEP: begin
        if (r == c) o.step_status = ST_NOP;
        else o.step_status = eliminate(req == REQ_COL_STEP, r, c);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_item(req_e req, int unsigned r, int unsigned c, logic [31:0] wv);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'd0, wv, c[3:0], r[3:0], req};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(predict(req, r, c, wv));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[33:0];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got.read_value !== want.read_value || got.step_status !== want.step_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                     want.read_value, got.read_value, want.step_status, got.step_status);
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom();
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h5_ffff) - 32'h3_0000;
    endcase
  endfunction

  // Every entry is written first so no read ever touches an unwritten location.
  task automatic test_fill();
    for (int unsigned r = 0; r < Dim; r++) begin
      for (int unsigned c = 0; c < Dim; c++) send_item(REQ_WR_MAT, r, c, rand_value());
      send_item(REQ_WR_VEC, r, 0, rand_value());
    end
  endtask

  task automatic test_directed();
    send_item(REQ_WR_MAT, 3, 3, 32'h7fff_ffff);
    send_item(REQ_WR_MAT, 5, 3, 32'h8000_0000);
    send_item(REQ_ROW_STEP, 5, 3, 0);
    send_item(REQ_RD_MAT, 5, 3, 0);
    send_item(REQ_RD_MAT, 3, 3, 0);
    send_item(REQ_RD_VEC, 5, 0, 0);
    send_item(REQ_WR_MAT, 2, 2, 32'h0005_0000);
    send_item(REQ_WR_MAT, 2, 9, 32'hfffb_0000);
    send_item(REQ_COL_STEP, 2, 9, 0);
    send_item(REQ_RD_MAT, 0, 9, 0);
    send_item(REQ_WR_MAT, 4, 4, 0);
    send_item(REQ_WR_MAT, 7, 4, 0);
    send_item(REQ_ROW_STEP, 7, 4, 0);
    send_item(REQ_COL_STEP, 6, 6, 0);
    send_item(REQ_WR_MAT, 15, 15, 32'h0001_0000);
    send_item(REQ_WR_MAT, 15, 0, 32'h0003_0000);
    send_item(REQ_COL_STEP, 15, 0, 0);
    send_item(REQ_ROW_STEP, 15, 0, 0);
    send_item(REQ_RD_MAT, 15, 15, 0);
    send_item(REQ_RD_VEC, 15, 0, 0);
    send_item(REQ_RD_VEC, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    int unsigned k, r, c;
    idle_pct = idle;
    stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(0, 15);
      r = $urandom_range(0, Dim-1);
      c = ($urandom_range(0, 9) == 0) ? r : $urandom_range(0, Dim-1);
      if (k < 3) send_item(REQ_WR_MAT, r, c, rand_value());
      else if (k < 4) send_item(REQ_WR_VEC, r, c, rand_value());
      else if (k < 6) send_item(REQ_RD_MAT, r, c, $urandom());
      else if (k < 7) send_item(REQ_RD_VEC, r, c, $urandom());
      else if (k < 11) send_item(REQ_ROW_STEP, r, c, $urandom());
      else send_item(REQ_COL_STEP, r, c, $urandom());
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_fill();
    test_directed();
    test_random(365, 0, 0);
    test_random(365, 72, 0);
    test_random(365, 0, 72);
    test_random(362, 22, 22);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== pivoted_pairwise_elimination.f =====
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_ctrl.sv
hw/rtl/ppe_dp.sv
hw/rtl/pivoted_pairwise_elimination.sv
verif/tb_top.sv
